@@ hw/rtl/sgml_entity_decoder_defines.svh @@
// ----------------------------------------------------------------------------
// SGML entity decoder assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SGML_ENTITY_DECODER_DEFINES_SVH
`define SGML_ENTITY_DECODER_DEFINES_SVH

// Plain property checked on every rising edge
`define SED_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication
`define SED_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define SED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg
// Types, character codes and the entity name ROM of the entity decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int DEF_MAX_NAME_LEN = 8;
  localparam int DEF_MAX_DIGITS   = 5;

  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  localparam int ROM_N = 252;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_FLUSH
  } dp_op_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_FLUSH
  } ctrl_state_t;

  typedef enum logic [2:0] {
    K_START,
    K_HASH,
    K_DIGIT,
    K_NAME,
    K_PASS,
    K_DONE,
    K_FAIL
  } step_kind_t;

  typedef struct packed {
    dp_op_t op;
    logic   last;
  } dp_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic q_one;
    logic p_zero;
    logic p_one;
    logic emits;
    logic fail;
    logic out_free;
  } dp_stat_t;

  // Names are right-justified: the first character sits in the highest nonzero byte
  localparam logic [63:0] ROM_NAME [ROM_N] = '{
    "emsp","ensp","nbsp",
    "iexcl","cent","pound","curren","yen",
    "brvbar","sect","uml","copy","ordf",
    "laquo","not","shy","reg","macr",
    "deg","plusmn","sup2","sup3","acute",
    "micro","para","middot","cedil","sup1",
    "ordm","raquo","frac14","frac12","frac34",
    "iquest","Agrave","Aacute","Acirc","Atilde",
    "Auml","Aring","AElig","Ccedil","Egrave",
    "Eacute","Ecirc","Euml","Igrave","Iacute",
    "Icirc","Iuml","ETH","Ntilde","Ograve",
    "Oacute","Ocirc","Otilde","Ouml","times",
    "Oslash","Ugrave","Uacute","Ucirc","Uuml",
    "Yacute","THORN","szlig","agrave","aacute",
    "acirc","atilde","auml","aring","aelig",
    "ccedil","egrave","eacute","ecirc","euml",
    "igrave","iacute","icirc","iuml","eth",
    "ntilde","ograve","oacute","ocirc","otilde",
    "ouml","divide","oslash","ugrave","uacute",
    "ucirc","uuml","yacute","thorn","yuml",
    "fnof",
    "Alpha","Beta","Gamma","Delta","Epsilon",
    "Zeta","Eta","Theta","Iota","Kappa",
    "Lambda","Mu","Nu","Xi","Omicron",
    "Pi","Rho","Sigma","Tau","Upsilon",
    "Phi","Chi","Psi","Omega",
    "alpha","beta","gamma","delta","epsilon",
    "zeta","eta","theta","iota","kappa",
    "lambda","mu","nu","xi","omicron",
    "pi","rho","sigmaf","sigma","tau",
    "upsilon","phi","chi","psi","omega",
    "thetasym","upsih","piv",
    "bull","hellip","prime","Prime",
    "oline","frasl",
    "weierp","image","real","trade",
    "alefsym",
    "larr","uarr","rarr","darr","harr",
    "crarr","lArr","uArr","rArr","dArr",
    "hArr",
    "forall","part","exist","empty",
    "nabla","isin","notin","ni","prod",
    "sum","minus","lowast","radic",
    "prop","infin","ang","and","or",
    "cap","cup","int","there4","sim",
    "cong","asymp","ne","equiv","le",
    "ge","sub","sup","nsub","sube",
    "supe","oplus","otimes","perp",
    "sdot",
    "lceil","rceil","lfloor","rfloor",
    "lang","rang","loz",
    "spades","clubs","hearts","diams",
    "quot","amp","lt","gt",
    "OElig","oelig","Scaron","scaron","Yuml",
    "circ","tilde",
    "thinsp","zwnj","zwj","lrm","rlm",
    "ndash","mdash","lsquo","rsquo",
    "sbquo","ldquo","rdquo","bdquo",
    "dagger","Dagger","permil","lsaquo",
    "rsaquo","euro"
  };

  localparam logic [15:0] ROM_CODE [ROM_N] = '{
    16'd32,16'd32,16'd32,
    16'd161,16'd162,16'd163,16'd164,16'd165,
    16'd166,16'd167,16'd168,16'd169,16'd170,
    16'd171,16'd172,16'd173,16'd174,16'd175,
    16'd176,16'd177,16'd178,16'd179,16'd180,
    16'd181,16'd182,16'd183,16'd184,16'd185,
    16'd186,16'd187,16'd188,16'd189,16'd190,
    16'd191,16'd192,16'd193,16'd194,16'd195,
    16'd196,16'd197,16'd198,16'd199,16'd200,
    16'd201,16'd202,16'd203,16'd204,16'd205,
    16'd206,16'd207,16'd208,16'd209,16'd210,
    16'd211,16'd212,16'd213,16'd214,16'd215,
    16'd216,16'd217,16'd218,16'd219,16'd220,
    16'd221,16'd222,16'd223,16'd224,16'd225,
    16'd226,16'd227,16'd228,16'd229,16'd230,
    16'd231,16'd232,16'd233,16'd234,16'd235,
    16'd236,16'd237,16'd238,16'd239,16'd240,
    16'd241,16'd242,16'd243,16'd244,16'd245,
    16'd246,16'd247,16'd248,16'd249,16'd250,
    16'd251,16'd252,16'd253,16'd254,16'd255,
    16'd402,
    16'd913,16'd914,16'd915,16'd916,16'd917,
    16'd918,16'd919,16'd920,16'd921,16'd922,
    16'd923,16'd924,16'd925,16'd926,16'd927,
    16'd928,16'd929,16'd931,16'd932,16'd933,
    16'd934,16'd935,16'd936,16'd937,
    16'd945,16'd946,16'd947,16'd948,16'd949,
    16'd950,16'd951,16'd952,16'd953,16'd954,
    16'd955,16'd956,16'd957,16'd958,16'd959,
    16'd960,16'd961,16'd962,16'd963,16'd964,
    16'd965,16'd966,16'd967,16'd968,16'd969,
    16'd977,16'd978,16'd982,
    16'd8226,16'd8230,16'd8242,16'd8243,
    16'd8254,16'd8260,
    16'd8472,16'd8465,16'd8476,16'd8482,
    16'd8501,
    16'd8592,16'd8593,16'd8594,16'd8595,16'd8596,
    16'd8629,16'd8656,16'd8657,16'd8658,16'd8659,
    16'd8660,
    16'd8704,16'd8706,16'd8707,16'd8709,
    16'd8711,16'd8712,16'd8713,16'd8715,16'd8719,
    16'd8721,16'd8722,16'd8727,16'd8730,
    16'd8733,16'd8734,16'd8736,16'd8743,16'd8744,
    16'd8745,16'd8746,16'd8747,16'd8756,16'd8764,
    16'd8773,16'd8776,16'd8800,16'd8801,16'd8804,
    16'd8805,16'd8834,16'd8835,16'd8836,16'd8838,
    16'd8839,16'd8853,16'd8855,16'd8869,
    16'd8901,
    16'd8968,16'd8969,16'd8970,16'd8971,
    16'd9001,16'd9002,16'd9674,
    16'd9824,16'd9827,16'd9829,16'd9830,
    16'd34,16'd38,16'd60,16'd62,
    16'd338,16'd339,16'd352,16'd353,16'd376,
    16'd710,16'd732,
    16'd8201,16'd8204,16'd8205,16'd8206,16'd8207,
    16'd8211,16'd8212,16'd8216,16'd8217,
    16'd8218,16'd8220,16'd8221,16'd8222,
    16'd8224,16'd8225,16'd8240,16'd8249,
    16'd8250,16'd8364
  };

  function automatic logic [3:0] name_len(logic [63:0] nm);
    logic [3:0] len;
    len = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (nm[8*i +: 8] != 8'h00) len = len + 4'd1;
    end
    return len;
  endfunction

  function automatic logic [7:0] name_char(logic [63:0] nm, int j);
    int len;
    logic [7:0] ch;
    len = int'(name_len(nm));
    ch = 8'h00;
    for (int pos = 0; pos < 8; pos++) begin
      if (j < len && pos == len - 1 - j) ch = nm[8*pos +: 8];
    end
    return ch;
  endfunction

endpackage

@@ hw/rtl/sgml_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// sgml_entity_decoder
// HTML 4 character reference decoder: text bytes in, 16-bit code units out.
// ----------------------------------------------------------------------------
// Each accepted byte is loaded into the queue and then scanned, and a new byte
// is taken only once the queue is empty. A reference that fails replays its
// held bytes through the scan step, one byte per cycle while no emitting step
// waits; a word marked end_of_text also flushes the held bytes one per cycle
// while the output register is free. Emitting steps wait while the output
// register is full. Names are matched against the entity ROM through a
// candidate mask narrowed one character per scan cycle.
module sgml_entity_decoder #(
  parameter int MAX_NAME_LEN = sed_pkg::DEF_MAX_NAME_LEN,
  parameter int MAX_DIGITS   = sed_pkg::DEF_MAX_DIGITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_text,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] code_unit,
  output logic        last_unit
);
  import sed_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sed_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .end_of_text (end_of_text),
    .stat        (stat),
    .cmd         (cmd)
  );

  sed_datapath #(
    .MAX_NAME_LEN (MAX_NAME_LEN),
    .MAX_DIGITS   (MAX_DIGITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_unit (code_unit),
    .last_unit (last_unit)
  );

endmodule

@@ hw/rtl/sed_ctrl.sv @@
// ----------------------------------------------------------------------------
// sed_ctrl
// Sequencer: loads words, steps the scan queue and flushes at end of text.
// ----------------------------------------------------------------------------
`include "sgml_entity_decoder_defines.svh"

module sed_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             end_of_text,
  input  sed_pkg::dp_stat_t stat,
  output sed_pkg::dp_cmd_t  cmd
);
  import sed_pkg::*;

  ctrl_state_t state, state_next;
  logic        eot, eot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      eot   <= 1'b0;
    end else begin
      state <= state_next;
      eot   <= eot_next;
    end
  end

  always_comb begin
    state_next = state;
    eot_next   = eot;
    cmd.op     = CMD_NONE;
    cmd.last   = 1'b0;
    in_ready   = 1'b0;
    unique case (state)
      ST_RUN: begin
        if (!stat.q_empty) begin
          // hold a step that emits until the output register frees up
          if (!stat.emits) begin
            cmd.op = CMD_STEP;
          end else if (stat.out_free) begin
            cmd.op   = CMD_STEP;
            cmd.last = eot && !stat.fail && stat.q_one;
          end
        end else if (eot) begin
          state_next = ST_FLUSH;
        end else begin
          in_ready = 1'b1;
          if (in_valid) begin
            cmd.op   = CMD_LOAD;
            eot_next = end_of_text;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.p_zero) begin
          state_next = ST_RUN;
          eot_next   = 1'b0;
        end else if (stat.out_free) begin
          cmd.op   = CMD_FLUSH;
          cmd.last = stat.p_one;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

  `SED_ASSERT_IMP(a_flush_has_slot, cmd.op == CMD_FLUSH, stat.out_free, "flush without output slot")
  `SED_ASSERT_NXT(a_load_fills_queue, in_valid && in_ready, !stat.q_empty, "loaded word missing")
  `SED_ASSERT_NXT(a_flush_done_clears, state == ST_FLUSH && stat.p_zero, !eot && state == ST_RUN, "end of text not cleared")
  `SED_ASSERT(a_ready_only_idle, !in_ready || (stat.q_empty && !eot), "ready while busy")

endmodule

@@ hw/rtl/sed_datapath.sv @@
// ----------------------------------------------------------------------------
// sed_datapath
// Byte queue with pending reference prefix, name candidate mask, decimal
// accumulator and output register.
// ----------------------------------------------------------------------------
module sed_datapath #(
  parameter int MAX_NAME_LEN = sed_pkg::DEF_MAX_NAME_LEN,
  parameter int MAX_DIGITS   = sed_pkg::DEF_MAX_DIGITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  sed_pkg::dp_cmd_t  cmd,
  output sed_pkg::dp_stat_t stat,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [15:0]       code_unit,
  output logic              last_unit
);
  import sed_pkg::*;

  localparam int BUF_LEN = ((MAX_NAME_LEN + 2) > (MAX_DIGITS + 3)) ?
                           (MAX_NAME_LEN + 2) : (MAX_DIGITS + 3);
  localparam int CW = $clog2(BUF_LEN + 1);

  // bytes [0, p) are the pending reference, [p, n) wait to be scanned
  logic [7:0]       buf_q [BUF_LEN];
  logic [7:0]       buf_shift [BUF_LEN];
  logic [CW-1:0]    p, n;
  logic             is_num;
  logic [15:0]      val;
  logic [ROM_N-1:0] cand, cand_next, cand_init, hit;
  logic [15:0]      hit_code;
  logic             any_hit;
  logic [7:0]       b;
  step_kind_t       kind;
  logic [CW-1:0]    shamt;
  logic [15:0]      emit_code;
  logic [15:0]      val_next;
  logic             is_digit;
  logic             emit_now;

  always_comb begin
    b = buf_q[0];
    for (int i = 0; i < BUF_LEN; i++) begin
      if (p == CW'(i)) b = buf_q[i];
    end
  end

  // name match against the ROM at character position p-1
  always_comb begin
    hit_code = 16'h0000;
    for (int i = 0; i < ROM_N; i++) begin
      cand_init[i] = (int'(name_len(ROM_NAME[i])) <= MAX_NAME_LEN);
      cand_next[i] = 1'b0;
      for (int jj = 0; jj < 8; jj++) begin
        if (p == CW'(jj + 1) && jj < int'(name_len(ROM_NAME[i])) &&
            name_char(ROM_NAME[i], jj) == b) begin
          cand_next[i] = cand[i];
        end
      end
      hit[i] = cand[i] && ((CW'(name_len(ROM_NAME[i])) + CW'(1)) == p);
      if (hit[i]) hit_code = hit_code | ROM_CODE[i];
    end
    any_hit = |hit;
  end

  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign val_next = {val[12:0], 3'b000} + {val[14:0], 1'b0} + {12'h000, b[3:0]};

  always_comb begin
    priority if (p == '0) begin
      kind = (b == CH_AMP) ? K_START : K_PASS;
    end else if (p == CW'(1) && b == CH_HASH) begin
      kind = K_HASH;
    end else if (is_num) begin
      priority if (is_digit && p < CW'(MAX_DIGITS + 2)) kind = K_DIGIT;
      else if (b == CH_SEMI && p >= CW'(3))            kind = K_DONE;
      else                                              kind = K_FAIL;
    end else if (b == CH_SEMI) begin
      kind = (p >= CW'(2) && any_hit) ? K_DONE : K_FAIL;
    end else begin
      kind = (p < CW'(MAX_NAME_LEN + 1) && |cand_next) ? K_NAME : K_FAIL;
    end
  end

  always_comb begin
    unique case (kind)
      K_PASS:  emit_code = {8'h00, b};
      K_DONE:  emit_code = is_num ? val : hit_code;
      default: emit_code = {8'h00, buf_q[0]};
    endcase
    if (cmd.op == CMD_FLUSH) emit_code = {8'h00, buf_q[0]};
  end

  assign shamt = (cmd.op == CMD_STEP && kind == K_DONE) ? (p + CW'(1)) : CW'(1);

  always_comb begin
    for (int i = 0; i < BUF_LEN; i++) begin
      buf_shift[i] = buf_q[i];
      for (int s = 1; s < BUF_LEN - i; s++) begin
        if (shamt == CW'(s)) buf_shift[i] = buf_q[i + s];
      end
    end
  end

  always_comb begin
    stat.q_empty  = (n == p);
    stat.q_one    = (n == p + CW'(1));
    stat.p_zero   = (p == '0);
    stat.p_one    = (p == CW'(1));
    stat.emits    = (kind == K_PASS) || (kind == K_DONE) || (kind == K_FAIL);
    stat.fail     = (kind == K_FAIL);
    stat.out_free = !out_valid || out_ready;
  end

  assign emit_now = ((cmd.op == CMD_STEP) && stat.emits) || (cmd.op == CMD_FLUSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p <= '0;
      n <= '0;
    end else begin
      unique case (cmd.op)
        CMD_LOAD: begin
          n <= n + CW'(1);
        end
        CMD_STEP: begin
          unique case (kind)
            K_START: p <= CW'(1);
            K_HASH, K_DIGIT, K_NAME: p <= p + CW'(1);
            default: begin
              p <= '0;
              n <= n - shamt;
            end
          endcase
        end
        CMD_FLUSH: begin
          p <= p - CW'(1);
          n <= n - CW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      CMD_LOAD: begin
        for (int i = 0; i < BUF_LEN; i++) begin
          if (n == CW'(i)) buf_q[i] <= in_byte;
        end
      end
      CMD_STEP: begin
        unique case (kind)
          K_START: begin
            cand   <= cand_init;
            is_num <= 1'b0;
            val    <= 16'h0000;
          end
          K_HASH:  is_num <= 1'b1;
          K_DIGIT: val <= val_next;
          K_NAME:  cand <= cand_next;
          default: begin
            buf_q     <= buf_shift;
            code_unit <= emit_code;
            last_unit <= cmd.last;
          end
        endcase
      end
      CMD_FLUSH: begin
        buf_q     <= buf_shift;
        code_unit <= emit_code;
        last_unit <= cmd.last;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ bench/tb_sgml_entity_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_sgml_entity_decoder
// Self-checking bench for the entity decoder: named, numeric and broken
// references plus random text go in, and every code unit that comes out is
// checked against a behavioral copy of the decoder kept inside the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sgml_entity_decoder;
  import sed_pkg::*;

  localparam int HOLD_DEPTH = 10;
  localparam int NAME_MAX   = 8;
  localparam int DIGIT_MAX  = 5;
  localparam int STALL_LIMIT = 3000;

  typedef struct {
    logic [7:0] txt;
    logic       eot;
  } text_word_t;

  typedef struct {
    logic [15:0] code;
    logic        last;
  } unit_word_t;

  typedef enum {SCAN_BREAK, SCAN_HOLD, SCAN_DONE} scan_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h20;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] code_unit;
  logic        last_unit;

  text_word_t text_q[$];
  unit_word_t unit_q[$];
  logic [7:0] held[HOLD_DEPTH];
  int         held_cnt = 0;
  int         n_sent = 0;
  int         n_total = 0;
  int         errors = 0;
  int         stall_cnt = 0;
  int         send_idle = 24;
  int         recv_idle = 73;

  sgml_entity_decoder dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_byte(in_byte), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_ready(out_ready),
    .code_unit(code_unit), .last_unit(last_unit)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Index of an entity whose first k characters equal the held name bytes
  function automatic int find_entity(int k, bit exact);
    int len;
    bit ok;
    for (int i = 0; i < ROM_N; i++) begin
      len = 0;
      for (int p = 0; p < 8; p++) if (ROM_NAME[i][8*p +: 8] != 8'h00) len++;
      if (len > NAME_MAX || k > len || (exact && len != k)) continue;
      ok = 1'b1;
      for (int j = 0; j < k; j++)
        if (ROM_NAME[i][8*(len-1-j) +: 8] != held[1+j]) ok = 1'b0;
      if (ok) return i;
    end
    return -1;
  endfunction

  function automatic void push_unit(logic [15:0] code);
    unit_word_t u;
    u.code = code;
    u.last = 1'b0;
    unit_q.push_back(u);
  endfunction

  function automatic void decode_byte(logic [7:0] first, logic eot);
    logic [7:0] scan_q[$];
    logic [7:0] redo_q[$];
    logic [7:0] b;
    int cnt;
    int n;
    int e;
    scan_res_t res;
    logic [31:0] code;
    scan_q.push_back(first);
    n = 0;
    while (scan_q.size() > 0) begin
      b = scan_q.pop_front();
      cnt = held_cnt;
      res = SCAN_BREAK;
      code = 0;
      if (cnt == 0) begin
        if (b == CH_AMP) begin
          held[0] = b;
          held_cnt = 1;
        end else begin
          push_unit({8'h00, b});
          n++;
        end
        continue;
      end
      if (cnt == 1 && b == CH_HASH) begin
        res = SCAN_HOLD;
      end else if (cnt >= 2 && held[1] == CH_HASH) begin
        if (b >= CH_ZERO && b <= CH_NINE && cnt - 2 < DIGIT_MAX) begin
          res = SCAN_HOLD;
        end else if (b == CH_SEMI && cnt - 2 >= 1) begin
          for (int i = 2; i < cnt; i++) code = code * 10 + (held[i] - CH_ZERO);
          res = SCAN_DONE;
        end
      end else if (b == CH_SEMI) begin
        e = (cnt - 1 >= 1) ? find_entity(cnt - 1, 1'b1) : -1;
        if (e >= 0) begin
          code = ROM_CODE[e];
          res = SCAN_DONE;
        end
      end else if (cnt - 1 < NAME_MAX && cnt < HOLD_DEPTH) begin
        held[cnt] = b;
        if (find_entity(cnt, 1'b0) >= 0) res = SCAN_HOLD;
      end
      if (res == SCAN_HOLD) begin
        if (cnt < HOLD_DEPTH) begin
          held[cnt] = b;
          held_cnt = cnt + 1;
        end
      end else if (res == SCAN_DONE) begin
        push_unit(code[15:0]);
        n++;
        held_cnt = 0;
      end else begin
        // emit the '&' as a literal and rescan everything after it
        push_unit({8'h00, held[0]});
        n++;
        redo_q = {};
        for (int i = 1; i < cnt; i++) redo_q.push_back(held[i]);
        redo_q.push_back(b);
        scan_q = {redo_q, scan_q};
        held_cnt = 0;
      end
    end
    if (eot) begin
      for (int i = 0; i < held_cnt; i++) begin
        push_unit({8'h00, held[i]});
        n++;
      end
      held_cnt = 0;
      if (n > 0) unit_q[unit_q.size()-1].last = 1'b1;
    end
  endfunction

  task automatic add_byte(logic [7:0] b, logic eot);
    text_word_t w;
    w.txt = b;
    w.eot = eot;
    text_q.push_back(w);
  endtask

  task automatic add_text(string s, logic eot);
    for (int i = 0; i < s.len(); i++) add_byte(s[i], eot && i == s.len() - 1);
  endtask

  task automatic add_random_entity();
    int idx;
    int len;
    logic [7:0] ch;
    int bad;
    idx = $urandom_range(ROM_N - 1);
    len = 0;
    for (int p = 0; p < 8; p++) if (ROM_NAME[idx][8*p +: 8] != 8'h00) len++;
    bad = ($urandom_range(9) == 0) ? $urandom_range(len) : -1;
    add_byte(CH_AMP, 1'b0);
    for (int j = 0; j < len; j++) begin
      ch = ROM_NAME[idx][8*(len-1-j) +: 8];
      add_byte(j == bad ? 8'($urandom_range(1, 255)) : ch, 1'b0);
    end
    if (bad != len) add_byte(CH_SEMI, $urandom_range(15) == 0);
  endtask

  task automatic add_random_number();
    int nd;
    nd = $urandom_range(1, 6);
    add_byte(CH_AMP, 1'b0);
    add_byte(CH_HASH, 1'b0);
    for (int j = 0; j < nd; j++) add_byte(CH_ZERO + 8'($urandom_range(9)), 1'b0);
    if ($urandom_range(9) != 0) add_byte(CH_SEMI, $urandom_range(15) == 0);
  endtask

  // Driver: hold the word until accepted, then advance or idle
  always @(posedge clk) begin
    text_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) n_sent++;
      if (n_sent < n_total / 3) begin
        send_idle = 24;
        recv_idle = 73;
      end else if (n_sent < 2 * n_total / 3) begin
        send_idle = 73;
        recv_idle = 24;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if (text_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        w = text_q.pop_front();
        in_valid <= 1'b1;
        in_byte <= w.txt;
        end_of_text <= w.eot;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: predict on accepted input, check accepted output
  always @(posedge clk) begin
    unit_word_t exp_u;
    if (!rst) begin
      if (in_valid && in_ready) decode_byte(in_byte, end_of_text);
      if (out_valid && out_ready) begin
        if (unit_q.size() == 0) begin
          $display("%0t: unexpected unit code=%h last=%b", $time, code_unit, last_unit);
          errors++;
        end else begin
          exp_u = unit_q.pop_front();
          if (code_unit !== exp_u.code) begin
            $display("%0t: code_unit expected %h actual %h", $time, exp_u.code, code_unit);
            errors++;
          end
          if (last_unit !== exp_u.last) begin
            $display("%0t: last_unit expected %b actual %b", $time, exp_u.last, last_unit);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("%0t: timeout, no word moved", $time);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int r;
    add_text("a&amp;", 1'b0);
    add_text("&#65535;&#99999;", 1'b0);
    add_text("&#123456;&;&#;", 1'b0);
    add_text("&nbsp;&thetasym;&euro;", 1'b0);
    add_text("&am&lt;&xyz", 1'b1);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h01, 1'b1);
    add_text("&Omeg", 1'b1);
    while (text_q.size() < 330) begin
      r = $urandom_range(99);
      if (r < 40) add_random_entity();
      else if (r < 60) add_random_number();
      else add_byte(8'($urandom_range(1, 255)), $urandom_range(19) == 0);
    end
    n_total = text_q.size();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    while (text_q.size() != 0 || in_valid || unit_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (unit_q.size() != 0) begin
      $display("%0t: %0d units never arrived", $time, unit_q.size());
      errors++;
    end
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
